// File: hw/rtl/lpdc_pkg.sv
// Shared constants, types and the class colour table of the point transform.
`default_nettype none

package lpdc_pkg;

    // Histogram geometry
    localparam int CLASS_BINS = 256;
    localparam int BIN_W      = $clog2(CLASS_BINS);
    localparam int CLS_W      = 8;
    localparam int COUNT_W    = 32;

    // Coordinate widths
    localparam int RAW_W   = 32;
    localparam int SCALE_W = 32;
    localparam int BIAS_W  = 64;
    localparam int AXIS_W  = 48;
    localparam int PROD_W  = 64;
    localparam int SUM_W   = 66;
    localparam int FRAC_DROP = 8;   // Q.24 down to Q.16

    localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(128);
    localparam logic signed [AXIS_W-1:0] Q16_MAX = {1'b0, {(AXIS_W-1){1'b1}}};
    localparam logic signed [AXIS_W-1:0] Q16_MIN = {1'b1, {(AXIS_W-1){1'b0}}};

    // Stream widths
    localparam int S_DATA_W = 112;
    localparam int M_DATA_W = 504;

    // Configuration port
    localparam int CFG_ADDR_W = 6;
    localparam int CFG_DATA_W = 64;
    localparam int PF_W       = 4;

    localparam logic [2:0] REG_SCALE_X      = 3'd0;
    localparam logic [2:0] REG_SCALE_Y      = 3'd1;
    localparam logic [2:0] REG_SCALE_Z      = 3'd2;
    localparam logic [2:0] REG_BIAS_X       = 3'd3;
    localparam logic [2:0] REG_BIAS_Y       = 3'd4;
    localparam logic [2:0] REG_BIAS_Z       = 3'd5;
    localparam logic [2:0] REG_POINT_FORMAT = 3'd6;

    localparam logic [SCALE_W-1:0] SCALE_ONE = 32'h0100_0000;
    localparam logic [PF_W-1:0]    PF_EXTENDED_MIN = 4'd6;

    // Class codes that own a colour
    localparam logic [CLS_W-1:0] CLS_GROUND     = 8'd2;
    localparam logic [CLS_W-1:0] CLS_LOW_VEG    = 8'd3;
    localparam logic [CLS_W-1:0] CLS_MED_VEG    = 8'd4;
    localparam logic [CLS_W-1:0] CLS_HIGH_VEG   = 8'd5;
    localparam logic [CLS_W-1:0] CLS_BUILDING   = 8'd6;
    localparam logic [CLS_W-1:0] CLS_LOW_NOISE  = 8'd7;
    localparam logic [CLS_W-1:0] CLS_WATER      = 8'd9;
    localparam logic [CLS_W-1:0] CLS_BRIDGE     = 8'd17;
    localparam logic [CLS_W-1:0] CLS_HIGH_NOISE = 8'd18;

    // Histogram control from the pipeline
    typedef struct packed {
        logic rd_en;     // new item entering stage 1 reads its bin
        logic upd_en;    // stage 1 item moves on and updates its bin
        logic in_range;  // stage 1 class has a bin
    } hist_ctl_t;

    function automatic logic [31:0] pack_rgb(input logic [7:0] r, input logic [7:0] g,
                                             input logic [7:0] b);
        return {8'hFF, b, g, r};
    endfunction

    function automatic logic [31:0] class_colour(input logic [CLS_W-1:0] c);
        logic [31:0] rgba;
        case (c)
            CLS_GROUND:     rgba = pack_rgb(8'd166, 8'd124, 8'd82);
            CLS_LOW_VEG:    rgba = pack_rgb(8'd130, 8'd190, 8'd90);
            CLS_MED_VEG:    rgba = pack_rgb(8'd70,  8'd155, 8'd70);
            CLS_HIGH_VEG:   rgba = pack_rgb(8'd30,  8'd110, 8'd50);
            CLS_BUILDING:   rgba = pack_rgb(8'd190, 8'd190, 8'd195);
            CLS_LOW_NOISE:  rgba = pack_rgb(8'd220, 8'd80,  8'd220);
            CLS_WATER:      rgba = pack_rgb(8'd55,  8'd125, 8'd210);
            CLS_BRIDGE:     rgba = pack_rgb(8'd225, 8'd150, 8'd55);
            CLS_HIGH_NOISE: rgba = pack_rgb(8'd230, 8'd65,  8'd65);
            default:        rgba = pack_rgb(8'd220, 8'd220, 8'd220);
        endcase
        return rgba;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/lpdc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module lpdc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // read returns the contents before a same-edge write
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/lpdc_axis.sv
// One coordinate axis: multiply by scale, add bias, round to Q32.16, saturate.
`default_nettype none

module lpdc_axis (
    input  wire logic                                aclk,
    input  wire logic                                ld_mul,
    input  wire logic                                ld_sum,
    input  wire logic signed [lpdc_pkg::RAW_W-1:0]   raw,
    input  wire logic        [lpdc_pkg::SCALE_W-1:0] scale,
    input  wire logic signed [lpdc_pkg::BIAS_W-1:0]  bias,
    output logic      signed [lpdc_pkg::AXIS_W-1:0]  axis
);

    localparam int T_W = lpdc_pkg::SUM_W - lpdc_pkg::FRAC_DROP;

    logic signed [lpdc_pkg::RAW_W:0]        raw_ext;
    logic signed [lpdc_pkg::SCALE_W:0]      scale_ext;
    logic signed [lpdc_pkg::SUM_W-1:0]      prod_full;
    logic signed [lpdc_pkg::PROD_W-1:0]     prod_reg;
    logic signed [lpdc_pkg::SUM_W-1:0]      sum_next;
    logic signed [lpdc_pkg::SUM_W-1:0]      sum_reg;
    logic signed [T_W-1:0]                  trunc;
    logic                                   fits;

    assign raw_ext   = {raw[lpdc_pkg::RAW_W-1], raw};
    assign scale_ext = {1'b0, scale};
    assign prod_full = lpdc_pkg::SUM_W'(raw_ext) * lpdc_pkg::SUM_W'(scale_ext);

    // exact Q.24 sum plus half an LSB of Q.16
    assign sum_next = lpdc_pkg::SUM_W'(prod_reg) + lpdc_pkg::SUM_W'(bias)
                    + lpdc_pkg::ROUND_HALF;

    always_ff @(posedge aclk) begin
        if (ld_mul) begin
            prod_reg <= prod_full[lpdc_pkg::PROD_W-1:0];
        end
        if (ld_sum) begin
            sum_reg <= sum_next;
        end
    end

    // floor by 256, then clamp to 48 bits
    assign trunc = sum_reg[lpdc_pkg::SUM_W-1:lpdc_pkg::FRAC_DROP];
    assign fits  = (&trunc[T_W-1:lpdc_pkg::AXIS_W-1])
                 | ~(|trunc[T_W-1:lpdc_pkg::AXIS_W-1]);

    always_comb begin
        if (fits) begin
            axis = trunc[lpdc_pkg::AXIS_W-1:0];
        end else if (trunc[T_W-1]) begin
            axis = lpdc_pkg::Q16_MIN;
        end else begin
            axis = lpdc_pkg::Q16_MAX;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/lpdc_hist.sv
// Class histogram: RAM with per-bin valid bits and same-edge write forwarding.
`default_nettype none

module lpdc_hist (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire lpdc_pkg::hist_ctl_t                 ctl,
    input  wire logic [lpdc_pkg::BIN_W-1:0]          rd_bin,
    input  wire logic [lpdc_pkg::BIN_W-1:0]          upd_bin,
    output logic      [lpdc_pkg::COUNT_W-1:0]        count
);

    logic [lpdc_pkg::CLASS_BINS-1:0] valid_reg;
    logic [lpdc_pkg::COUNT_W-1:0]    ram_q;
    logic                            byp_hit_reg;
    logic [lpdc_pkg::COUNT_W-1:0]    byp_val_reg;
    logic                            rdv_reg;
    logic [lpdc_pkg::COUNT_W-1:0]    cnt_old;
    logic [lpdc_pkg::COUNT_W-1:0]    cnt_new;
    logic                            wr_en;

    assign wr_en = ctl.upd_en & ctl.in_range;

    lpdc_ram #(
        .WIDTH (lpdc_pkg::COUNT_W),
        .DEPTH (lpdc_pkg::CLASS_BINS)
    ) u_ram (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (upd_bin),
        .wdata (cnt_new),
        .re    (ctl.rd_en),
        .raddr (rd_bin),
        .rdata (ram_q)
    );

    // a bin never written reads as zero; a write on the read edge is forwarded
    assign cnt_old = byp_hit_reg ? byp_val_reg : (rdv_reg ? ram_q : '0);
    assign cnt_new = (&cnt_old) ? cnt_old : cnt_old + lpdc_pkg::COUNT_W'(1);
    assign count   = ctl.in_range ? cnt_new : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg   <= '0;
            byp_hit_reg <= 1'b0;
            rdv_reg     <= 1'b0;
        end else begin
            if (wr_en) begin
                valid_reg[upd_bin] <= 1'b1;
            end
            if (ctl.rd_en) begin
                byp_hit_reg <= wr_en && (upd_bin == rd_bin);
                rdv_reg     <= valid_reg[rd_bin];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.rd_en) begin
            byp_val_reg <= cnt_new;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/lidar_point_dequantize_classify.sv
// Top level: LiDAR point dequantise, Y-up reorder, class colour, histogram and bounds.
//
// Input stream (s_*) carries one raw point per item: signed X, Y, Z and the
// legacy and extended class codes. Output stream (m_*) carries one result per
// item: east/up/north in signed Q32.16, RGBA colour, chosen class, the bin
// count after increment and the running per-axis minimum and maximum.
// Registers are written over the APB port at byte address 8*index; the user must
// write them only while no item is in flight, which the block does not enforce;
// pready is tied high and reads return register contents. Pipeline: three
// stages. Stage 1 holds the 33x33 products and the histogram read; stage 2 the
// exact Q.24 sums and the updated bin count (written back as the item leaves
// stage 1, forwarded to a following item of the same class); stage 3 is the
// output register, where bounds are updated. m_tvalid rises as an item enters
// stage 3; one item per cycle sustained while the output is not stalled. Each
// stage moves on its own, so bubbles close up and s_tready falls only when all
// three stages hold items and the output is stalled.
// Reset restores the registers to their defaults (scales 1.0, biases 0,
// format 0), empties the pipeline, sets bounds to their extreme values and
// clears the per-bin valid bits, so every bin reads zero at once.
`default_nettype none

module lidar_point_dequantize_classify (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    // raw_x[31:0], raw_y[63:32], raw_z[95:64], legacy_class[100:96],
    // extended_class[108:101], zero pad [111:109]
    input  wire logic [lpdc_pkg::S_DATA_W-1:0]        s_tdata,
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    // local_east[47:0], local_up[95:48], local_north[143:96],
    // rgba_color[175:144], chosen_class[183:176], class_count[215:184],
    // min_east[263:216], min_up[311:264], min_north[359:312],
    // max_east[407:360], max_up[455:408], max_north[503:456]
    output logic [lpdc_pkg::M_DATA_W-1:0]             m_tdata,
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [lpdc_pkg::CFG_ADDR_W-1:0]      paddr,
    input  wire logic [lpdc_pkg::CFG_DATA_W-1:0]      pwdata,
    output logic      [lpdc_pkg::CFG_DATA_W-1:0]      prdata,
    output logic                                      pready
);

    localparam int AW = lpdc_pkg::AXIS_W;

    // ---------------- configuration ----------------
    logic [lpdc_pkg::SCALE_W-1:0]       scale_x_reg, scale_y_reg, scale_z_reg;
    logic signed [lpdc_pkg::BIAS_W-1:0] bias_x_reg, bias_y_reg, bias_z_reg;
    logic [lpdc_pkg::PF_W-1:0]          pf_reg;
    logic [2:0]                         reg_idx;
    logic                               cfg_wr;

    assign pready  = 1'b1;
    assign reg_idx = paddr[5:3];
    assign cfg_wr  = psel & penable & pwrite & pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_x_reg <= lpdc_pkg::SCALE_ONE;
            scale_y_reg <= lpdc_pkg::SCALE_ONE;
            scale_z_reg <= lpdc_pkg::SCALE_ONE;
            bias_x_reg  <= '0;
            bias_y_reg  <= '0;
            bias_z_reg  <= '0;
            pf_reg      <= '0;
        end else if (cfg_wr) begin
            case (reg_idx)
                lpdc_pkg::REG_SCALE_X:      scale_x_reg <= pwdata[31:0];
                lpdc_pkg::REG_SCALE_Y:      scale_y_reg <= pwdata[31:0];
                lpdc_pkg::REG_SCALE_Z:      scale_z_reg <= pwdata[31:0];
                lpdc_pkg::REG_BIAS_X:       bias_x_reg  <= pwdata;
                lpdc_pkg::REG_BIAS_Y:       bias_y_reg  <= pwdata;
                lpdc_pkg::REG_BIAS_Z:       bias_z_reg  <= pwdata;
                lpdc_pkg::REG_POINT_FORMAT: pf_reg      <= pwdata[3:0];
                default: ;  // unmapped: ignored
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            lpdc_pkg::REG_SCALE_X:      prdata = 64'(scale_x_reg);
            lpdc_pkg::REG_SCALE_Y:      prdata = 64'(scale_y_reg);
            lpdc_pkg::REG_SCALE_Z:      prdata = 64'(scale_z_reg);
            lpdc_pkg::REG_BIAS_X:       prdata = bias_x_reg;
            lpdc_pkg::REG_BIAS_Y:       prdata = bias_y_reg;
            lpdc_pkg::REG_BIAS_Z:       prdata = bias_z_reg;
            lpdc_pkg::REG_POINT_FORMAT: prdata = 64'(pf_reg);
            default:                    prdata = '0;
        endcase
    end

    // ---------------- handshake ----------------
    logic v1_reg, v2_reg, v3_reg;
    logic rdy1, rdy2, rdy3;
    logic acc, mv12, mv23;

    assign rdy3     = ~v3_reg | m_tready;
    assign rdy2     = ~v2_reg | rdy3;
    assign rdy1     = ~v1_reg | rdy2;
    assign s_tready = rdy1;
    assign m_tvalid = v3_reg;
    assign acc      = s_tvalid & rdy1;
    assign mv12     = v1_reg & rdy2;
    assign mv23     = v2_reg & rdy3;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= s_tvalid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
        end
    end

    // ---------------- input fields and class select ----------------
    logic signed [31:0]             raw_x, raw_y, raw_z;
    logic [4:0]                     legacy_class;
    logic [7:0]                     extended_class;
    logic [lpdc_pkg::CLS_W-1:0]     cls_in;

    assign raw_x          = s_tdata[31:0];
    assign raw_y          = s_tdata[63:32];
    assign raw_z          = s_tdata[95:64];
    assign legacy_class   = s_tdata[100:96];
    assign extended_class = s_tdata[108:101];
    assign cls_in = (pf_reg >= lpdc_pkg::PF_EXTENDED_MIN) ? extended_class
                                                          : 8'(legacy_class);

    // ---------------- axes (east = X, up = Z, north = Y) ----------------
    logic signed [AW-1:0] east, up, north;

    lpdc_axis u_east (
        .aclk (aclk), .ld_mul (acc), .ld_sum (mv12),
        .raw (raw_x), .scale (scale_x_reg), .bias (bias_x_reg), .axis (east)
    );
    lpdc_axis u_up (
        .aclk (aclk), .ld_mul (acc), .ld_sum (mv12),
        .raw (raw_z), .scale (scale_z_reg), .bias (bias_z_reg), .axis (up)
    );
    lpdc_axis u_north (
        .aclk (aclk), .ld_mul (acc), .ld_sum (mv12),
        .raw (raw_y), .scale (scale_y_reg), .bias (bias_y_reg), .axis (north)
    );

    // ---------------- histogram ----------------
    logic [lpdc_pkg::CLS_W-1:0]   cls1_reg, cls2_reg;
    logic [lpdc_pkg::COUNT_W-1:0] cnt1, cnt2_reg;
    lpdc_pkg::hist_ctl_t          hctl;

    assign hctl.rd_en    = acc;
    assign hctl.upd_en   = mv12;
    assign hctl.in_range = 9'(cls1_reg) < 9'(lpdc_pkg::CLASS_BINS);

    lpdc_hist u_hist (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (hctl),
        .rd_bin  (cls_in[lpdc_pkg::BIN_W-1:0]),
        .upd_bin (cls1_reg[lpdc_pkg::BIN_W-1:0]),
        .count   (cnt1)
    );

    always_ff @(posedge aclk) begin
        if (acc) begin
            cls1_reg <= cls_in;
        end
        if (mv12) begin
            cls2_reg <= cls1_reg;
            cnt2_reg <= cnt1;
        end
    end

    // ---------------- bounds and output register ----------------
    logic signed [AW-1:0] lo_e_reg, lo_u_reg, lo_n_reg;
    logic signed [AW-1:0] hi_e_reg, hi_u_reg, hi_n_reg;
    logic signed [AW-1:0] lo_e_next, lo_u_next, lo_n_next;
    logic signed [AW-1:0] hi_e_next, hi_u_next, hi_n_next;

    assign lo_e_next = (east  < lo_e_reg) ? east  : lo_e_reg;
    assign lo_u_next = (up    < lo_u_reg) ? up    : lo_u_reg;
    assign lo_n_next = (north < lo_n_reg) ? north : lo_n_reg;
    assign hi_e_next = (east  > hi_e_reg) ? east  : hi_e_reg;
    assign hi_u_next = (up    > hi_u_reg) ? up    : hi_u_reg;
    assign hi_n_next = (north > hi_n_reg) ? north : hi_n_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lo_e_reg <= lpdc_pkg::Q16_MAX;
            lo_u_reg <= lpdc_pkg::Q16_MAX;
            lo_n_reg <= lpdc_pkg::Q16_MAX;
            hi_e_reg <= lpdc_pkg::Q16_MIN;
            hi_u_reg <= lpdc_pkg::Q16_MIN;
            hi_n_reg <= lpdc_pkg::Q16_MIN;
        end else if (mv23) begin
            lo_e_reg <= lo_e_next;
            lo_u_reg <= lo_u_next;
            lo_n_reg <= lo_n_next;
            hi_e_reg <= hi_e_next;
            hi_u_reg <= hi_u_next;
            hi_n_reg <= hi_n_next;
        end
    end

    logic signed [AW-1:0]         o_east_reg, o_up_reg, o_north_reg;
    logic [31:0]                  o_rgba_reg;
    logic [lpdc_pkg::CLS_W-1:0]   o_cls_reg;
    logic [lpdc_pkg::COUNT_W-1:0] o_cnt_reg;

    always_ff @(posedge aclk) begin
        if (mv23) begin
            o_east_reg  <= east;
            o_up_reg    <= up;
            o_north_reg <= north;
            o_rgba_reg  <= lpdc_pkg::class_colour(cls2_reg);
            o_cls_reg   <= cls2_reg;
            o_cnt_reg   <= cnt2_reg;
        end
    end

    // bounds registers already include the item held in the output stage
    assign m_tdata = {hi_n_reg, hi_u_reg, hi_e_reg, lo_n_reg, lo_u_reg, lo_e_reg,
                      o_cnt_reg, o_cls_reg, o_rgba_reg,
                      o_north_reg, o_up_reg, o_east_reg};

    // ---------------- assertions ----------------
    logic o_in_range;
    assign o_in_range = 9'(o_cls_reg) < 9'(lpdc_pkg::CLASS_BINS);

    // a counted class has at least this item in its bin
    a_count_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && o_in_range) |-> (o_cnt_reg != '0))
        else $error("class_count zero for an in-range class");

    // each output coordinate lies within the bounds sent with it
    a_bounds_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (lo_e_reg <= o_east_reg && o_east_reg <= hi_e_reg
                   && lo_u_reg <= o_up_reg && o_up_reg <= hi_u_reg
                   && lo_n_reg <= o_north_reg && o_north_reg <= hi_n_reg))
        else $error("output coordinate outside running bounds");

    // back-pressure only when every stage is occupied
    a_ready_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (v1_reg && v2_reg && v3_reg && !m_tready))
        else $error("input stalled with a free pipeline stage");

    // a histogram write always belongs to an item leaving stage 1
    a_hist_write: assert property (@(posedge aclk) disable iff (!aresetn)
        hctl.upd_en |-> (v1_reg && rdy2))
        else $error("histogram update without a moving item");

endmodule

`default_nettype wire

// File: tb/sv/tb_lidar_point_dequantize_classify.sv
// Self-checking testbench for the LiDAR point dequantise and classify block.
module tb_lidar_point_dequantize_classify;
    timeunit 1ns;
    timeprecision 1ps;

    // Cycles with no item moving on either side before the run is abandoned.
    // Worst honest gap is a stalled receiver plus the APB accesses of a register setting.
    localparam int STALL_LIMIT        = 5000;
    localparam int POINTS_PER_SETTING = 280;
    localparam int SHOWN_ERRORS       = 40;

    // Register slot past the end of the map; writes there must be dropped
    localparam logic [2:0] REG_UNUSED = 3'd7;

    // Q.24 sums at or above the top, or below the floor, saturate once rounded to Q.16
    localparam logic signed [65:0] Q24_TOP   = 66'sh7F_FFFF_FFFF_FF80;
    localparam logic signed [65:0] Q24_FLOOR = -66'sh80_0000_0000_0080;

    // Input item, first field in the lowest bits
    typedef struct packed {
        logic [2:0]  pad;
        logic [7:0]  extended_class;
        logic [4:0]  legacy_class;
        logic [31:0] raw_z;
        logic [31:0] raw_y;
        logic [31:0] raw_x;
    } point_t;

    // Result item, local_east in the lowest bits
    typedef struct packed {
        logic [47:0] max_north;
        logic [47:0] max_up;
        logic [47:0] max_east;
        logic [47:0] min_north;
        logic [47:0] min_up;
        logic [47:0] min_east;
        logic [31:0] class_count;
        logic [7:0]  chosen_class;
        logic [31:0] rgba_color;
        logic [47:0] local_north;
        logic [47:0] local_up;
        logic [47:0] local_east;
    } local_point_t;

    // ------------------------------------------------------------------
    // DUT connections; every input known from time zero
    // ------------------------------------------------------------------
    logic                            aclk     = 1'b0;
    logic                            aresetn  = 1'b0;
    logic [lpdc_pkg::S_DATA_W-1:0]   s_tdata  = '0;
    logic                            s_tvalid = 1'b0;
    wire logic                       s_tready;
    wire logic [lpdc_pkg::M_DATA_W-1:0] m_tdata;
    wire logic                       m_tvalid;
    logic                            m_tready = 1'b0;
    logic                            psel     = 1'b0;
    logic                            penable  = 1'b0;
    logic                            pwrite   = 1'b0;
    logic [lpdc_pkg::CFG_ADDR_W-1:0] paddr    = '0;
    logic [lpdc_pkg::CFG_DATA_W-1:0] pwdata   = '0;
    wire logic [lpdc_pkg::CFG_DATA_W-1:0] prdata;
    wire logic                       pready;

    lidar_point_dequantize_classify uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor state: registers, histogram and running bounds
    // Axis order for bounds: 0 east, 1 up, 2 north. Scale/bias: 0 x, 1 y, 2 z.
    // ------------------------------------------------------------------
    logic [31:0] cur_scale [3];
    logic [63:0] cur_bias [3];
    logic [3:0]  cur_format;
    logic [31:0] bin_count [lpdc_pkg::CLASS_BINS];
    logic [47:0] low_seen [3];
    logic [47:0] high_seen [3];
    logic [7:0]  recent_class = '0;

    local_point_t pending_points [$];

    int send_idle = 37;
    int recv_idle = 76;
    int mismatches;
    int points_sent;
    int results_seen;
    int settings_loaded;
    int regs_checked;
    int quiet_cycles;

    local_point_t want_point;
    local_point_t seen_point;

    // raw * scale + bias exactly in Q.24, rounded half up to Q.16, saturated to 48 bits
    function automatic logic [47:0] dequantize(logic [31:0] raw, logic [31:0] scale,
                                               logic [63:0] bias);
        logic signed [65:0] total;
        logic signed [65:0] rounded;
        total = $signed({{34{raw[31]}}, raw}) * $signed({34'd0, scale})
              + $signed({{2{bias[63]}}, bias});
        if (total >= Q24_TOP)
            return lpdc_pkg::Q16_MAX;
        if (total < Q24_FLOOR)
            return lpdc_pkg::Q16_MIN;
        rounded = (total + 66'sd128) >>> lpdc_pkg::FRAC_DROP;
        return rounded[47:0];
    endfunction

    function automatic logic [31:0] palette(logic [7:0] cls);
        logic [23:0] bgr;
        case (cls)
            lpdc_pkg::CLS_GROUND:     bgr = {8'd82,  8'd124, 8'd166};
            lpdc_pkg::CLS_LOW_VEG:    bgr = {8'd90,  8'd190, 8'd130};
            lpdc_pkg::CLS_MED_VEG:    bgr = {8'd70,  8'd155, 8'd70};
            lpdc_pkg::CLS_HIGH_VEG:   bgr = {8'd50,  8'd110, 8'd30};
            lpdc_pkg::CLS_BUILDING:   bgr = {8'd195, 8'd190, 8'd190};
            lpdc_pkg::CLS_LOW_NOISE:  bgr = {8'd220, 8'd80,  8'd220};
            lpdc_pkg::CLS_WATER:      bgr = {8'd210, 8'd125, 8'd55};
            lpdc_pkg::CLS_BRIDGE:     bgr = {8'd55,  8'd150, 8'd225};
            lpdc_pkg::CLS_HIGH_NOISE: bgr = {8'd65,  8'd65,  8'd230};
            default:                  bgr = {8'd220, 8'd220, 8'd220};   // light grey
        endcase
        return {8'hFF, bgr};
    endfunction

    // Advances the predictor by one point and returns what the block must emit
    function automatic local_point_t classify_point(point_t pt);
        local_point_t res;
        logic [47:0]  axis [3];
        logic [7:0]   cls;
        axis[0] = dequantize(pt.raw_x, cur_scale[0], cur_bias[0]);
        axis[1] = dequantize(pt.raw_z, cur_scale[2], cur_bias[2]);
        axis[2] = dequantize(pt.raw_y, cur_scale[1], cur_bias[1]);
        // formats six and up count as extended
        cls = (cur_format >= lpdc_pkg::PF_EXTENDED_MIN) ? pt.extended_class
                                                        : {3'b000, pt.legacy_class};
        res.class_count = '0;
        if (int'(cls) < lpdc_pkg::CLASS_BINS) begin
            if (bin_count[cls] != '1)
                bin_count[cls] = bin_count[cls] + 1;
            res.class_count = bin_count[cls];
        end
        for (int a = 0; a < 3; a++) begin
            if ($signed(axis[a]) < $signed(low_seen[a]))
                low_seen[a] = axis[a];
            if ($signed(axis[a]) > $signed(high_seen[a]))
                high_seen[a] = axis[a];
        end
        res.local_east   = axis[0];
        res.local_up     = axis[1];
        res.local_north  = axis[2];
        res.rgba_color   = palette(cls);
        res.chosen_class = cls;
        res.min_east     = low_seen[0];
        res.min_up       = low_seen[1];
        res.min_north    = low_seen[2];
        res.max_east     = high_seen[0];
        res.max_up       = high_seen[1];
        res.max_north    = high_seen[2];
        return res;
    endfunction

    function automatic void apply_reg(logic [2:0] idx, logic [63:0] value);
        case (idx)
            lpdc_pkg::REG_SCALE_X:      cur_scale[0] = value[31:0];
            lpdc_pkg::REG_SCALE_Y:      cur_scale[1] = value[31:0];
            lpdc_pkg::REG_SCALE_Z:      cur_scale[2] = value[31:0];
            lpdc_pkg::REG_BIAS_X:       cur_bias[0]  = value;
            lpdc_pkg::REG_BIAS_Y:       cur_bias[1]  = value;
            lpdc_pkg::REG_BIAS_Z:       cur_bias[2]  = value;
            lpdc_pkg::REG_POINT_FORMAT: cur_format   = value[3:0];
            default: ;        // nothing lives past the format register
        endcase
    endfunction

    function automatic logic [63:0] reg_value(logic [2:0] idx);
        case (idx)
            lpdc_pkg::REG_SCALE_X:      return {32'd0, cur_scale[0]};
            lpdc_pkg::REG_SCALE_Y:      return {32'd0, cur_scale[1]};
            lpdc_pkg::REG_SCALE_Z:      return {32'd0, cur_scale[2]};
            lpdc_pkg::REG_BIAS_X:       return cur_bias[0];
            lpdc_pkg::REG_BIAS_Y:       return cur_bias[1];
            lpdc_pkg::REG_BIAS_Z:       return cur_bias[2];
            lpdc_pkg::REG_POINT_FORMAT: return {60'd0, cur_format};
            default:                    return '0;
        endcase
    endfunction

    function automatic point_t make_point(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                          logic [4:0] legacy, logic [7:0] extended);
        point_t pt;
        pt.pad            = '0;
        pt.raw_x          = x;
        pt.raw_y          = y;
        pt.raw_z          = z;
        pt.legacy_class   = legacy;
        pt.extended_class = extended;
        return pt;
    endfunction

    // Mostly modest coordinates, some full-range, a few at the ends
    function automatic logic [31:0] random_raw();
        logic [31:0] ends [4];
        ends = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF};
        case ($urandom_range(9))
            0:       return ends[$urandom_range(3)];
            1, 2:    return $urandom;
            default: return 32'($urandom_range(200000)) - 32'd100000;
        endcase
    endfunction

    // Repeats of the last class keep back-to-back hits on one histogram bin common
    function automatic logic [7:0] random_class();
        logic [7:0] coloured [9];
        coloured = '{lpdc_pkg::CLS_GROUND, lpdc_pkg::CLS_LOW_VEG, lpdc_pkg::CLS_MED_VEG,
                     lpdc_pkg::CLS_HIGH_VEG, lpdc_pkg::CLS_BUILDING,
                     lpdc_pkg::CLS_LOW_NOISE, lpdc_pkg::CLS_WATER, lpdc_pkg::CLS_BRIDGE,
                     lpdc_pkg::CLS_HIGH_NOISE};
        case ($urandom_range(9))
            0, 1, 2, 3: ;
            4, 5, 6:    recent_class = coloured[$urandom_range(8)];
            default:    recent_class = 8'($urandom);
        endcase
        return recent_class;
    endfunction

    function automatic point_t random_point();
        logic [7:0] legacy;
        logic [7:0] extended;
        legacy   = random_class();
        extended = random_class();
        return make_point(random_raw(), random_raw(), random_raw(), legacy[4:0], extended);
    endfunction

    // ------------------------------------------------------------------
    // Bus tasks
    // ------------------------------------------------------------------
    task automatic send_point(input point_t pt);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tdata  <= pt;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        pending_points.push_back(classify_point(pt));
        points_sent++;
    endtask

    // Lowers valid and waits for the pipeline to empty
    task automatic drain_points();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_points.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Setup then access phase; registers sit at byte address 8*index
    task automatic apb_access(input logic is_write, input logic [2:0] idx,
                              input logic [63:0] wdata, output logic [63:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= {idx, 3'b000};
        pwdata  <= wdata;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready)
            @(posedge aclk);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic compare_field(input string name, input logic [63:0] want,
                                 input logic [63:0] seen);
        if (want !== seen) begin
            mismatches++;
            if (mismatches <= SHOWN_ERRORS)
                $display("%0t: %s mismatch: expected %h, got %h", $time, name, want, seen);
        end
    endtask

    task automatic check_reg(input logic [2:0] idx);
        logic [63:0] rd;
        apb_access(1'b0, idx, '0, rd);
        compare_field($sformatf("register %0d readback", idx), reg_value(idx), rd);
        regs_checked++;
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
        logic [63:0] unused_rd;
        apb_access(1'b1, idx, value, unused_rd);
        apply_reg(idx, value);
        if (idx != REG_UNUSED)
            check_reg(idx);
    endtask

    task automatic check_all_regs();
        for (int i = lpdc_pkg::REG_SCALE_X; i <= lpdc_pkg::REG_POINT_FORMAT; i++)
            check_reg(3'(i));
    endtask

    // Only called with the pipeline empty
    task automatic load_setting(input logic [31:0] sx, input logic [31:0] sy,
                                input logic [31:0] sz, input logic [63:0] bx,
                                input logic [63:0] by, input logic [63:0] bz,
                                input logic [3:0] fmt);
        write_reg(lpdc_pkg::REG_SCALE_X, {32'd0, sx});
        write_reg(lpdc_pkg::REG_SCALE_Y, {32'd0, sy});
        write_reg(lpdc_pkg::REG_SCALE_Z, {32'd0, sz});
        write_reg(lpdc_pkg::REG_BIAS_X, bx);
        write_reg(lpdc_pkg::REG_BIAS_Y, by);
        write_reg(lpdc_pkg::REG_BIAS_Z, bz);
        write_reg(lpdc_pkg::REG_POINT_FORMAT, {60'd0, fmt});
        settings_loaded++;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_register_defaults();
        check_all_regs();
    endtask

    // Default setting, legacy format: every coloured class plus unlisted ones
    task automatic test_class_colours();
        logic [4:0] codes [11];
        codes = '{lpdc_pkg::CLS_GROUND[4:0], lpdc_pkg::CLS_LOW_VEG[4:0],
                  lpdc_pkg::CLS_MED_VEG[4:0], lpdc_pkg::CLS_HIGH_VEG[4:0],
                  lpdc_pkg::CLS_BUILDING[4:0], lpdc_pkg::CLS_LOW_NOISE[4:0],
                  lpdc_pkg::CLS_WATER[4:0], lpdc_pkg::CLS_BRIDGE[4:0],
                  lpdc_pkg::CLS_HIGH_NOISE[4:0], 5'd0, 5'd31};
        foreach (codes[i])
            send_point(make_point(32'($urandom_range(2000)) - 32'd1000,
                                  32'($urandom_range(2000)) - 32'd1000,
                                  32'($urandom_range(2000)) - 32'd1000,
                                  codes[i], 8'($urandom)));
    endtask

    task automatic test_raw_extremes();
        send_point(make_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 5'd0, 8'h00));
        send_point(make_point(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 5'd31, 8'hFF));
    endtask

    // Class taken by format, including formats ten and fifteen; stray register write
    task automatic test_format_select();
        drain_points();
        load_setting(lpdc_pkg::SCALE_ONE, lpdc_pkg::SCALE_ONE, lpdc_pkg::SCALE_ONE,
                     '0, '0, '0, lpdc_pkg::PF_EXTENDED_MIN);
        send_point(make_point(32'd5, 32'd6, 32'd7, 5'd3, 8'hFF));
        drain_points();
        write_reg(lpdc_pkg::REG_POINT_FORMAT, 64'd10);
        send_point(make_point(32'd8, 32'd9, 32'd10, 5'd4, lpdc_pkg::CLS_BRIDGE));
        drain_points();
        write_reg(lpdc_pkg::REG_POINT_FORMAT, 64'd15);
        send_point(make_point(32'd11, 32'd12, 32'd13, lpdc_pkg::CLS_LOW_VEG[4:0],
                              lpdc_pkg::CLS_HIGH_NOISE));
        drain_points();
        write_reg(lpdc_pkg::REG_POINT_FORMAT, 64'd5);
        // index past the map must leave every register alone
        write_reg(REG_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF);
        check_all_regs();
        send_point(make_point(32'd14, 32'd15, 32'd16, 5'd1, lpdc_pkg::CLS_WATER));
    endtask

    // Scale of one LSB-half: products at exactly half a Q.16 step round up
    task automatic test_rounding();
        drain_points();
        load_setting(32'h80, 32'h80, 32'h80, '0, '0, '0, 4'd0);
        send_point(make_point(32'd1, 32'hFFFF_FFFF, 32'd3, 5'd0, 8'h00));
        send_point(make_point(32'hFFFF_FFFD, 32'd2, 32'hFFFF_FFFE, 5'd0, 8'h00));
        drain_points();
        // bias alone carries a half step: +0.5 and -0.5 in Q.16
        load_setting(32'h80, 32'h80, 32'h80, 64'h80, 64'hFFFF_FFFF_FFFF_FF80, 64'h7F, 4'd0);
        send_point(make_point(32'd0, 32'd0, 32'd0, 5'd2, 8'h00));
        send_point(make_point(32'd1, 32'd1, 32'hFFFF_FFFF, 5'd2, 8'h00));
    endtask

    // Zero scale, largest scale, and biases at both ends of their range
    task automatic test_saturation();
        drain_points();
        load_setting(32'd0, 32'hFFFF_FFFF, 32'd1, 64'h0000_0012_3456_7890, '0,
                     64'h8000_0000_0000_0000, 4'd0);
        send_point(make_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 5'd7, 8'h00));
        send_point(make_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 5'd9, 8'h00));
        send_point(make_point(32'd1, 32'hFFFF_FFFF, 32'd0, 5'd17, 8'h00));
        drain_points();
        // sums that overflow 64 bits saturate by the sign of the bias
        load_setting(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1, 64'h7FFF_FFFF_FFFF_FFFF,
                     64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF, 4'd0);
        send_point(make_point(32'h7FFF_FFFF, 32'h8000_0000, 32'd0, 5'd18, 8'h00));
        send_point(make_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 5'd6, 8'h00));
    endtask

    // Random points over random settings, in three idling regimes
    task automatic test_random_stream();
        int          send_pct [3];
        int          recv_pct [3];
        logic [31:0] sc [3];
        logic [63:0] bs [3];
        send_pct = '{37, 76, 0};
        recv_pct = '{76, 37, 0};
        for (int phase = 0; phase < 3; phase++) begin
            for (int setting = 0; setting < 2; setting++) begin
                drain_points();
                send_idle = send_pct[phase];
                recv_idle = recv_pct[phase];
                for (int a = 0; a < 3; a++) begin
                    case ($urandom_range(5))
                        0:       sc[a] = lpdc_pkg::SCALE_ONE;
                        1:       sc[a] = 32'($urandom_range(1, 200000));
                        2:       sc[a] = 32'hFFFF_FFFF;
                        3:       sc[a] = 32'($urandom_range(1, 1 << 24));
                        default: sc[a] = $urandom;
                    endcase
                    case ($urandom_range(5))
                        0:       bs[a] = '0;
                        1:       bs[a] = {$urandom, $urandom};
                        2:       bs[a] = 64'h7FFF_FFFF_FFFF_FFFF;
                        3:       bs[a] = 64'h8000_0000_0000_0000;
                        default: begin
                            bs[a] = 64'($urandom_range(1 << 30)) << 24;
                            if ($urandom_range(1))
                                bs[a] = -bs[a];
                        end
                    endcase
                end
                load_setting(sc[0], sc[1], sc[2], bs[0], bs[1], bs[2], 4'($urandom_range(15)));
                for (int n = 0; n < POINTS_PER_SETTING; n++) begin
                    // hold off once mid-setting until every result is back
                    if (setting == 0 && n == POINTS_PER_SETTING / 2)
                        drain_points();
                    send_point(random_point());
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver: random backpressure at the current rate
    // ------------------------------------------------------------------
    always @(posedge aclk)
        m_tready <= ($urandom_range(99) >= recv_idle);

    // Result checker: each result against the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (pending_points.size() == 0) begin
                mismatches++;
                if (mismatches <= SHOWN_ERRORS)
                    $display("%0t: result with no point pending: expected none, got %h",
                             $time, m_tdata);
            end else begin
                want_point = pending_points.pop_front();
                seen_point = m_tdata;
                compare_field("local_east",   want_point.local_east,   seen_point.local_east);
                compare_field("local_up",     want_point.local_up,     seen_point.local_up);
                compare_field("local_north",  want_point.local_north,  seen_point.local_north);
                compare_field("rgba_color",   want_point.rgba_color,   seen_point.rgba_color);
                compare_field("chosen_class", want_point.chosen_class, seen_point.chosen_class);
                compare_field("class_count",  want_point.class_count,  seen_point.class_count);
                compare_field("min_east",     want_point.min_east,     seen_point.min_east);
                compare_field("min_up",       want_point.min_up,       seen_point.min_up);
                compare_field("min_north",    want_point.min_north,    seen_point.min_north);
                compare_field("max_east",     want_point.max_east,     seen_point.max_east);
                compare_field("max_up",       want_point.max_up,       seen_point.max_up);
                compare_field("max_north",    want_point.max_north,    seen_point.max_north);
            end
        end
    end

    // Watchdog: too long with nothing accepted on either side
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no item moved for %0d cycles", $time, quiet_cycles);
            $display("tb_lidar_point_dequantize_classify NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        cur_scale  = '{lpdc_pkg::SCALE_ONE, lpdc_pkg::SCALE_ONE, lpdc_pkg::SCALE_ONE};
        cur_bias   = '{64'd0, 64'd0, 64'd0};
        cur_format = '0;
        foreach (bin_count[i])
            bin_count[i] = '0;
        low_seen   = '{lpdc_pkg::Q16_MAX, lpdc_pkg::Q16_MAX, lpdc_pkg::Q16_MAX};
        high_seen  = '{lpdc_pkg::Q16_MIN, lpdc_pkg::Q16_MIN, lpdc_pkg::Q16_MIN};

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_register_defaults();
        test_class_colours();
        test_raw_extremes();
        test_format_select();
        test_rounding();
        test_saturation();
        test_random_stream();

        drain_points();
        repeat (8) @(posedge aclk);

        $display("Checked %0d points (%0d results) across %0d register settings,",
                 points_sent, results_seen, settings_loaded);
        $display("all formats, colour classes, saturation, rounding; %0d register reads.",
                 regs_checked);
        if (mismatches == 0 && pending_points.size() == 0)
            $display("tb_lidar_point_dequantize_classify OK");
        else
            $display("tb_lidar_point_dequantize_classify NOT OK");
        $finish;
    end

endmodule

// File: files.f
hw/rtl/lpdc_pkg.sv
hw/rtl/lpdc_ram.sv
hw/rtl/lpdc_axis.sv
hw/rtl/lpdc_hist.sv
hw/rtl/lidar_point_dequantize_classify.sv
tb/sv/tb_lidar_point_dequantize_classify.sv
